@@ rtl/lhg_pkg.sv @@
package lhg_pkg;

	// Grade codes kept per link and reported on the result ports.
	typedef enum logic [1:0] {
		GRADE_UNKNOWN = 2'd0,
		GRADE_GOOD    = 2'd1,
		GRADE_IDLE    = 2'd2,
		GRADE_STALLED = 2'd3
	} grade_t;

	// Request codes.
	localparam logic REQ_SAMPLE  = 1'b0;
	localparam logic REQ_SIGNOFF = 1'b1;

	// Configuration register indexes.
	localparam logic [1:0] CFG_ENABLE  = 2'd0;
	localparam logic [1:0] CFG_IDLE    = 2'd1;
	localparam logic [1:0] CFG_STALLED = 2'd2;
	localparam logic [1:0] CFG_WEIGHT  = 2'd3;

	// Register reset values.
	localparam logic        RST_ENABLE  = 1'b1;
	localparam logic [15:0] RST_IDLE    = 16'd45;
	localparam logic [15:0] RST_STALLED = 16'd90;
	localparam logic [7:0]  RST_WEIGHT  = 8'd77;

	// Widths of the stored and reported values.
	localparam int TIME_W = 32;
	localparam int LAT_W  = 40;
	localparam int FRAC_W = 8;

	typedef struct packed {
		logic        enabled;
		logic [15:0] idle_limit;
		logic [15:0] stalled_limit;
		logic [7:0]  weight;
	} cfg_t;

	typedef struct packed {
		logic              req_type;
		logic              link_up;
		logic [TIME_W-1:0] last_rx;
		logic [TIME_W-1:0] now;
	} item_t;

	// One table entry as held in the link memory.
	typedef struct packed {
		grade_t            grade;
		logic [TIME_W-1:0] rx_time;
		logic [TIME_W-1:0] silence_start;
		logic [LAT_W-1:0]  latency;
	} entry_t;

	typedef struct packed {
		grade_t            grade;
		grade_t            prev_grade;
		logic              grade_changed;
		logic [TIME_W-1:0] silent_secs;
		logic [LAT_W-1:0]  latency_est;
	} result_t;

	// Table update requests from the datapath to the storage.
	typedef struct packed {
		logic write;
		logic clear;
	} upd_ctrl_t;

endpackage

@@ rtl/lhg_ram.sv @@
module lhg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/lhg_update.sv @@
module lhg_update (
	input  lhg_pkg::cfg_t      cfg,
	input  lhg_pkg::item_t     item,
	input  logic               in_range,
	input  lhg_pkg::entry_t    cur,
	output lhg_pkg::entry_t    nxt,
	output lhg_pkg::result_t   res,
	output lhg_pkg::upd_ctrl_t ctrl
);
	import lhg_pkg::*;

	logic [16:0]         idle_lim;
	logic [16:0]         stall_lim;
	logic [LAT_W-1:0]    obs;
	logic [47:0]         new_term;
	logic [48:0]         old_term;
	logic [48:0]         mix_sum;
	logic [LAT_W-1:0]    ewma;
	logic [TIME_W-1:0]   idle_cur;
	logic [TIME_W-1:0]   idle_new;
	grade_t              grade_new;

	// Effective thresholds: idle limit at least one, stall limit above the idle limit.
	always_comb begin
		idle_lim = (cfg.idle_limit == 16'd0) ? 17'd1 : {1'b0, cfg.idle_limit};
		if ({1'b0, cfg.stalled_limit} > idle_lim) begin
			stall_lim = {1'b0, cfg.stalled_limit};
		end else begin
			stall_lim = idle_lim + 17'd1;
		end
	end

	// Observed silence in fixed point and the smoothed latency with rounding.
	always_comb begin
		if (item.last_rx >= cur.silence_start) begin
			obs = {item.last_rx - cur.silence_start, {FRAC_W{1'b0}}};
		end else begin
			obs = '0;
		end
		new_term = 48'(cfg.weight) * 48'(obs);
		old_term = 49'(9'd256 - {1'b0, cfg.weight}) * 49'(cur.latency);
		mix_sum  = {1'b0, new_term} + old_term + 49'd128;
		ewma     = mix_sum[47:8];
	end

	// Next entry for a sample of a link that is up.
	always_comb begin
		nxt = cur;
		if (item.last_rx > cur.rx_time) begin
			if (cur.silence_start != '0) begin
				nxt.latency       = (cur.latency == '0) ? obs : ewma;
				nxt.silence_start = '0;
			end
			nxt.rx_time = item.last_rx;
		end else if (cur.silence_start == '0 && cur.rx_time != '0) begin
			nxt.silence_start = cur.rx_time;
		end
		if (nxt.rx_time != '0 && item.now >= nxt.rx_time) begin
			idle_new = item.now - nxt.rx_time;
		end else begin
			idle_new = '0;
		end
		if ({15'd0, idle_lim} > idle_new) begin
			grade_new = GRADE_GOOD;
		end else if ({15'd0, stall_lim} > idle_new) begin
			grade_new = GRADE_IDLE;
		end else begin
			grade_new = GRADE_STALLED;
		end
		nxt.grade = grade_new;
	end

	// Idle time from the stored entry, used while the link is down.
	always_comb begin
		if (cur.rx_time != '0 && item.now >= cur.rx_time) begin
			idle_cur = item.now - cur.rx_time;
		end else begin
			idle_cur = '0;
		end
	end

	// Result and table update for each kind of item.
	always_comb begin
		res  = '0;
		ctrl = '0;
		priority if (!in_range) begin
			res = '0;
		end else if (item.req_type == REQ_SIGNOFF) begin
			ctrl.clear     = 1'b1;
			res.prev_grade = cur.grade;
		end else if (!cfg.enabled) begin
			res.latency_est = cur.latency;
		end else if (!item.link_up) begin
			res.grade       = cur.grade;
			res.prev_grade  = cur.grade;
			res.silent_secs = idle_cur;
			res.latency_est = cur.latency;
		end else begin
			ctrl.write        = 1'b1;
			res.grade         = grade_new;
			res.prev_grade    = cur.grade;
			res.grade_changed = (grade_new != cur.grade);
			res.silent_secs   = idle_new;
			res.latency_est   = nxt.latency;
		end
	end

endmodule

@@ rtl/link_health_grader.sv @@
// Channel   Direction  Handshake                 Beat
// item      in         start & !busy             req_type, link_index, link_up,
//                                                last_rx_secs, now_secs
// result    out        done, one cycle           grade, prev_grade, grade_changed,
//                                                silent_secs, latency_est
// config    in         cfg_valid & cfg_ready     cfg_index, cfg_data
//
// One item is taken every clock cycle; busy stays low. The link memory is read
// in the cycle start is high, and the entry is updated in the next cycle; done
// and the result are driven from a result register loaded by that update.
// Back-to-back items on one link see each other through a one-entry write bypass.
// Reset clears the per-link valid bits at once, so no clearing pass is needed.
// The receiver cannot stall: each result is shown for exactly one cycle.
module link_health_grader #(
	parameter int MAX_LINKS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [5:0]  link_index,
	input  logic        link_up,
	input  logic [31:0] last_rx_secs,
	input  logic [31:0] now_secs,
	output logic        done,
	output logic [1:0]  grade,
	output logic [1:0]  prev_grade,
	output logic        grade_changed,
	output logic [31:0] silent_secs,
	output logic [39:0] latency_est,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import lhg_pkg::*;

	// Only 64 link numbers can be named, so deeper tables are cut to that.
	localparam int DEPTH   = (MAX_LINKS < 64) ? MAX_LINKS : 64;
	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int ENTRY_W = $bits(entry_t);

	cfg_t               cfg_q;
	logic               accept;
	logic               in_range;
	logic               valid_s1;
	logic               in_range_s1;
	logic [AW-1:0]      addr_s1;
	item_t              item_s1;
	logic [DEPTH-1:0]   entry_valid_q;
	logic [ENTRY_W-1:0] ram_rdata;
	logic               fwd_valid_q;
	logic [AW-1:0]      fwd_addr_q;
	entry_t             fwd_entry_q;
	entry_t             raw_entry;
	entry_t             cur_entry;
	entry_t             nxt_entry;
	result_t            upd_res;
	upd_ctrl_t          upd_ctrl;
	logic               wr_en;
	logic               done_q;
	result_t            res_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start & ~busy;
	assign in_range  = ({1'b0, link_index} < 7'(DEPTH));

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled       <= RST_ENABLE;
			cfg_q.idle_limit    <= RST_IDLE;
			cfg_q.stalled_limit <= RST_STALLED;
			cfg_q.weight        <= RST_WEIGHT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ENABLE:  cfg_q.enabled       <= cfg_data[0];
				CFG_IDLE:    cfg_q.idle_limit    <= cfg_data;
				CFG_STALLED: cfg_q.stalled_limit <= cfg_data;
				CFG_WEIGHT:  cfg_q.weight        <= cfg_data[7:0];
			endcase
		end
	end

	// Input stage register, loaded alongside the memory read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_range_s1      <= in_range;
			addr_s1          <= link_index[AW-1:0];
			item_s1.req_type <= req_type;
			item_s1.link_up  <= link_up;
			item_s1.last_rx  <= last_rx_secs;
			item_s1.now      <= now_secs;
		end
	end

	// Link memory holding grade, times and latency of each entry.
	lhg_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_link_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(addr_s1),
		.wdata(nxt_entry),
		.re   (accept),
		.raddr(link_index[AW-1:0]),
		.rdata(ram_rdata)
	);

	// Bypass of the entry written in the previous cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else begin
			fwd_valid_q <= wr_en;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_addr_q  <= addr_s1;
			fwd_entry_q <= nxt_entry;
		end
	end

	// Current entry: bypass or memory, read as all zero when not valid.
	always_comb begin
		if (fwd_valid_q && fwd_addr_q == addr_s1) begin
			raw_entry = fwd_entry_q;
		end else begin
			raw_entry = entry_t'(ram_rdata);
		end
		if (in_range_s1 && entry_valid_q[addr_s1]) begin
			cur_entry = raw_entry;
		end else begin
			cur_entry = '0;
		end
	end

	lhg_update u_update (
		.cfg     (cfg_q),
		.item    (item_s1),
		.in_range(in_range_s1),
		.cur     (cur_entry),
		.nxt     (nxt_entry),
		.res     (upd_res),
		.ctrl    (upd_ctrl)
	);

	assign wr_en = valid_s1 & upd_ctrl.write;

	// Per-link valid bits: set on a graded sample, cleared on sign-off.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
		end else if (valid_s1 && upd_ctrl.write) begin
			entry_valid_q[addr_s1] <= 1'b1;
		end else if (valid_s1 && upd_ctrl.clear) begin
			entry_valid_q[addr_s1] <= 1'b0;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			res_q <= upd_res;
		end
	end

	assign done          = done_q;
	assign grade         = res_q.grade;
	assign prev_grade    = res_q.prev_grade;
	assign grade_changed = res_q.grade_changed;
	assign silent_secs   = res_q.silent_secs;
	assign latency_est   = res_q.latency_est;

	// Every accepted item yields exactly one result.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("accepted item produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |=> !done)
		else $error("result without an accepted item");

	// A reported change must show differing grades.
	a_change_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(done && grade_changed) |-> (grade != prev_grade))
		else $error("change flag set with equal grades");

	// An item never both writes and clears an entry.
	a_write_or_clear: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $onehot0({upd_ctrl.write, upd_ctrl.clear}))
		else $error("entry written and cleared together");

endmodule
